FILE: rtl/core/ita_pkg.sv
`default_nettype none

package ita_pkg;

    localparam int DIGIT_W = 4;
    localparam int RADIX_W = 5;
    localparam int STEP_BITS = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 5'd10;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] DECIMAL_LIMIT = 8'd10;

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] digit,
                                              input logic lower);
        logic [7:0] wide_digit;
        wide_digit = {4'd0, digit};
        if (wide_digit < DECIMAL_LIMIT) begin
            return CHAR_ZERO + wide_digit;
        end
        else if (lower) begin
            return CHAR_LOWER_A + wide_digit - DECIMAL_LIMIT;
        end
        else begin
            return CHAR_UPPER_A + wide_digit - DECIMAL_LIMIT;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ita_divider.sv
`default_nettype none

module ita_divider #(
    parameter int QW = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [QW-1:0]                 dividend,
    input  wire logic [ita_pkg::RADIX_W-1:0]   divisor,
    output logic                               done,
    output logic [QW-1:0]                      quotient,
    output logic [ita_pkg::DIGIT_W-1:0]        remainder
);
    import ita_pkg::*;

    localparam int STEPS = QW / STEP_BITS;
    localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic              busy_reg;
    logic              done_reg;
    logic [SW-1:0]     step_reg;
    logic [QW-1:0]     quot_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [RADIX_W-1:0] div_reg;
    logic [QW-1:0]     quot_next;
    logic [DIGIT_W-1:0] rem_next;

    always_comb
    begin
        logic [RADIX_W-1:0] trial;
        logic [RADIX_W-1:0] diff;
        quot_next = quot_reg;
        rem_next = rem_reg;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            trial = {rem_next, quot_next[QW-1]};
            diff = trial - div_reg;
            if (trial >= div_reg)
            begin
                rem_next = diff[DIGIT_W-1:0];
                quot_next = {quot_next[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIGIT_W-1:0];
                quot_next = {quot_next[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            quot_reg <= '0;
            rem_reg <= '0;
            div_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                quot_reg <= dividend;
                rem_reg <= '0;
                div_reg <= divisor;
            end
            else if (busy_reg)
            begin
                quot_reg <= quot_next;
                rem_reg <= rem_next;
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/core/integer_to_ascii_radix.sv
// Each digit costs one pass of the shared divider, which retires four quotient bits per cycle.
// Digits are then read back from the digit memory, most significant first, one S_READ and S_OUT pass per character.
// A new transaction is taken as soon as the last character sits in the output register.
// Reset is asynchronous and active low; it returns the block to idle with no output pending.
`default_nettype none

module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [31:0]                   value,
    input  wire logic [ita_pkg::RADIX_W-1:0]   base,
    input  wire logic                          unsigned_mode,
    input  wire logic                          lowercase,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [7:0]                         character,
    output logic                               last
);
    import ita_pkg::*;

    localparam int QW = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int AW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIGN,
        S_START,
        S_WAIT,
        S_READ,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [RADIX_W-1:0] base_reg, base_next;
    logic [QW-1:0]      mag_reg, mag_next;
    logic               lower_reg, lower_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [7:0]         char_reg, char_next;
    logic               last_reg, last_next;

    logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];
    logic [DIGIT_W-1:0] rd_data_reg;

    logic [VALUE_WIDTH-1:0] in_val;
    logic [VALUE_WIDTH-1:0] in_neg_val;
    logic                   in_neg;
    logic                   out_free;
    logic                   div_start;
    logic                   div_done;
    logic [QW-1:0]          div_quot;
    logic [DIGIT_W-1:0]     div_rem;

    assign in_val = VALUE_WIDTH'(value);
    assign in_neg_val = ~in_val + VALUE_WIDTH'(1);
    assign in_neg = !unsigned_mode && in_val[VALUE_WIDTH-1];
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign div_start = (state_reg == S_START);

    ita_divider #(
        .QW(QW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (base_reg),
        .done     (div_done),
        .quotient (div_quot),
        .remainder(div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        base_next = base_reg;
        mag_next = mag_reg;
        lower_next = lower_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        char_next = char_reg;
        last_next = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (base < RADIX_MIN || base > RADIX_MAX)
                    begin
                        base_next = RADIX_DEFAULT;
                    end
                    else
                    begin
                        base_next = base;
                    end
                    lower_next = lowercase;
                    mag_next = in_neg ? QW'(in_neg_val) : QW'(in_val);
                    cnt_next = '0;
                    state_next = in_neg ? S_SIGN : S_START;
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    char_next = CHAR_MINUS;
                    last_next = 1'b0;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    cnt_next = cnt_reg + CW'(1);
                    mag_next = div_quot;
                    if (div_quot == '0 || cnt_reg == CW'(VALUE_WIDTH - 1))
                    begin
                        idx_next = cnt_reg[AW-1:0];
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    char_next = digit_char(rd_data_reg, lower_reg);
                    last_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - AW'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            base_reg <= RADIX_DEFAULT;
            mag_reg <= '0;
            lower_reg <= 1'b0;
            cnt_reg <= '0;
            idx_reg <= '0;
            rsp_valid_reg <= 1'b0;
            char_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg <= base_next;
            mag_reg <= mag_next;
            lower_reg <= lower_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WAIT && div_done)
        begin
            digit_mem[cnt_reg[AW-1:0]] <= div_rem;
        end
        rd_data_reg <= digit_mem[idx_reg];
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign character = char_reg;
    assign last = last_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("Block stayed idle after taking a transaction.");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_WAIT))
        else $error("Divider finished outside the wait state.");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(VALUE_WIDTH))
        else $error("Digit count exceeds the store depth.");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free && idx_reg == '0) |=>
            (state_reg == S_IDLE && rsp_valid_reg && last_reg))
        else $error("Final character did not close the conversion.");

endmodule

`default_nettype wire

FILE: bench/integer_to_ascii_radix_tb.sv
`default_nettype none

module integer_to_ascii_radix_tb;

    import ita_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } text_char_t;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    logic [31:0]          value;
    logic [RADIX_W-1:0]   base;
    logic                 unsigned_mode;
    logic                 lowercase;
    logic                 rsp_valid;
    logic                 rsp_stall;
    logic [7:0]           character;
    logic                 last;

    text_char_t text_expected[$];
    bit         calm;
    int         error_count;
    int         cycle_count;
    int         conversions_sent;
    int         chars_checked;

    integer_to_ascii_radix u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .value         (value),
        .base          (base),
        .unsigned_mode (unsigned_mode),
        .lowercase     (lowercase),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .character     (character),
        .last          (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Builds the expected character stream of one conversion, sign first.
    function automatic void predict_text(input logic [31:0] v, input logic [RADIX_W-1:0] b,
                                         input logic uns, input logic low);
        logic [31:0] radix;
        logic [31:0] mag;
        logic [3:0]  digits[$];
        logic [7:0]  ch;
        radix = (b < RADIX_MIN || b > RADIX_MAX) ? 32'(RADIX_DEFAULT) : 32'(b);
        mag = v;
        if (!uns && v[31])
        begin
            mag = -v;
            text_expected.push_back('{ch: CHAR_MINUS, fin: 1'b0});
        end
        do
        begin
            digits.push_front(4'(mag % radix));
            mag = mag / radix;
        end
        while (mag != 0);
        foreach (digits[i])
        begin
            if (digits[i] < 4'd10)
                ch = CHAR_ZERO + 8'(digits[i]);
            else
                ch = (low ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(digits[i]) - 8'd10;
            text_expected.push_back('{ch: ch, fin: (i == digits.size() - 1)});
        end
    endfunction

    always @(posedge clk)
    begin
        text_char_t exp_char;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            chars_checked++;
            if (text_expected.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                          character, last));
            end
            else
            begin
                exp_char = text_expected.pop_front();
                if (character !== exp_char.ch)
                    report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                              character, exp_char.ch));
                if (last !== exp_char.fin)
                    report_mismatch($sformatf("last %0b, expected %0b on character 0x%02h",
                                              last, exp_char.fin, exp_char.ch));
            end
        end
    end

    always @(negedge clk)
    begin
        rsp_stall <= !calm && ($urandom_range(99) < 26);
    end

    task automatic send_item(input logic [31:0] v, input logic [RADIX_W-1:0] b,
                             input logic uns, input logic low);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 26)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        value         <= v;
        base          <= b;
        unsigned_mode <= uns;
        lowercase     <= low;
        req_valid     <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        predict_text(v, b, uns, low);
        conversions_sent++;
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(255);
            2: return 32'hFFFF_FFFF - $urandom_range(255);
            3: return 32'h1 << $urandom_range(31);
            default: return $urandom ^ (32'h1 << $urandom_range(31));
        endcase
    endfunction

    function automatic logic [RADIX_W-1:0] random_base();
        if ($urandom_range(9) == 0)
            return RADIX_W'($urandom_range(31));
        return RADIX_W'($urandom_range(16, 2));
    endfunction

    task automatic test_zero_value();
        send_item(32'h0, 5'd10, 1'b0, 1'b0);
        send_item(32'h0, 5'd2, 1'b1, 1'b1);
    endtask

    task automatic test_sign_extremes();
        send_item(32'hFFFF_FFFF, 5'd2, 1'b1, 1'b0);
        send_item(32'hFFFF_FFFF, 5'd2, 1'b0, 1'b0);
        send_item(32'h8000_0000, 5'd2, 1'b0, 1'b0);
        send_item(32'h7FFF_FFFF, 5'd10, 1'b0, 1'b0);
        send_item(32'h8000_0000, 5'd16, 1'b0, 1'b1);
    endtask

    task automatic test_every_radix();
        for (int r = 2; r <= 16; r++)
            send_item(32'hDEAD_BEEF, RADIX_W'(r), r[0], r[1]);
    endtask

    task automatic test_fallback_radix();
        send_item(32'd12345, 5'd0, 1'b1, 1'b0);
        send_item(32'hFFFF_FF85, 5'd1, 1'b0, 1'b1);
        send_item(32'hFEDC_BA98, 5'd17, 1'b1, 1'b1);
        send_item(32'h9876_5432, 5'd31, 1'b0, 1'b0);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
            send_item(random_value(), random_base(), 1'($urandom), 1'($urandom));
    endtask

    task automatic test_back_to_back(input int count);
        calm = 1'b1;
        repeat (count)
            send_item(random_value(), random_base(), 1'($urandom), 1'($urandom));
        @(negedge clk);
        calm = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        value = '0;
        base = '0;
        unsigned_mode = 1'b0;
        lowercase = 1'b0;
        rsp_stall = 1'b0;
        calm = 1'b0;
        error_count = 0;
        cycle_count = 0;
        conversions_sent = 0;
        chars_checked = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_zero_value();
        test_sign_extremes();
        test_every_radix();
        test_fallback_radix();
        test_random_mix(54);
        test_back_to_back(30);

        @(negedge clk);
        req_valid <= 1'b0;
        while (text_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (text_expected.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived", text_expected.size()));

        $display("Converted %0d integers into %0d checked characters,", conversions_sent,
                 chars_checked);
        $display("covering all radixes, fallback radixes, both signs and both letter cases.");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
